// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SFC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define SFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/sfc_pkg.sv =====
// ---------------------------------------------------------------------------
// sfc_pkg
// Types, constants and plane-extraction helpers for the sphere frustum cull.
// ---------------------------------------------------------------------------
package sfc_pkg;

  localparam int NUM_PLANES = 6;

  // Configuration register indexes
  localparam logic [2:0] REG_CULL_EN  = 3'd0;
  localparam logic [2:0] REG_ROW0     = 3'd1;
  localparam logic [2:0] REG_ROW1     = 3'd2;
  localparam logic [2:0] REG_ROW2     = 3'd3;
  localparam logic [2:0] REG_ROW3_LO  = 3'd4;
  localparam logic [2:0] REG_ROW3_HI  = 3'd5;

  // Plane codes
  localparam logic [2:0] PL_LEFT   = 3'd0;
  localparam logic [2:0] PL_RIGHT  = 3'd1;
  localparam logic [2:0] PL_TOP    = 3'd2;
  localparam logic [2:0] PL_BOTTOM = 3'd3;
  localparam logic [2:0] PL_NEAR   = 3'd4;
  localparam logic [2:0] PL_FAR    = 3'd5;

  // Widths: Q5.12 plane coefficient times Q16.16 position, exact sums
  localparam int COEF_W = 17;
  localparam int CONST_W = 33;
  localparam int POS_W  = 32;
  localparam int RAD_W  = 31;
  localparam int PROD_W = COEF_W + POS_W;
  localparam int DIST_W = PROD_W + 2;
  localparam int FRAC_SHIFT = 12;

  typedef struct packed {
    logic signed [COEF_W-1:0]  x;
    logic signed [COEF_W-1:0]  y;
    logic signed [COEF_W-1:0]  z;
    logic signed [CONST_W-1:0] w;
  } plane_t;

  // Stage load enables for one plane lane
  typedef struct packed {
    logic ld_prod;
    logic ld_dist;
  } lane_ctl_t;

  // Q4.12 matrix row combined into one plane component
  function automatic logic signed [COEF_W-1:0] comb_q12(
    input logic [2:0] pl,
    input logic signed [15:0] c0, input logic signed [15:0] c1,
    input logic signed [15:0] c2, input logic signed [15:0] c3);
    logic signed [COEF_W-1:0] res;
    case (pl)
      PL_LEFT:   res = COEF_W'(c3) + COEF_W'(c0);
      PL_RIGHT:  res = COEF_W'(c3) - COEF_W'(c0);
      PL_TOP:    res = COEF_W'(c3) - COEF_W'(c1);
      PL_BOTTOM: res = COEF_W'(c3) + COEF_W'(c1);
      PL_NEAR:   res = COEF_W'(c2);
      default:   res = COEF_W'(c3) - COEF_W'(c2);
    endcase
    return res;
  endfunction

  // Q16.16 row 3 combined into the plane constant
  function automatic logic signed [CONST_W-1:0] comb_q16(
    input logic [2:0] pl,
    input logic signed [31:0] c0, input logic signed [31:0] c1,
    input logic signed [31:0] c2, input logic signed [31:0] c3);
    logic signed [CONST_W-1:0] res;
    case (pl)
      PL_LEFT:   res = CONST_W'(c3) + CONST_W'(c0);
      PL_RIGHT:  res = CONST_W'(c3) - CONST_W'(c0);
      PL_TOP:    res = CONST_W'(c3) - CONST_W'(c1);
      PL_BOTTOM: res = CONST_W'(c3) + CONST_W'(c1);
      PL_NEAR:   res = CONST_W'(c2);
      default:   res = CONST_W'(c3) - CONST_W'(c2);
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/sphere_frustum_cull.sv =====
// ---------------------------------------------------------------------------
// sphere_frustum_cull
// Bounding-sphere test against six unnormalised view-frustum planes.
// ---------------------------------------------------------------------------
// Takes one sphere per clock and returns one visible flag per sphere, in
// order, through the input register, then the product, distance and output
// registers. The six plane lanes each hold three 17x32 multipliers, which
// set the stage split; every stage has its own valid bit and stalls only when
// the stage after it is full and cannot move on, so the throughput is one
// sphere per cycle whenever the result side keeps taking. Planes come
// straight from the matrix registers; write them only while the pipeline is
// empty. With cull_enable low every sphere reports visible.
module sphere_frustum_cull
  import sfc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // configuration
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata,
  // sphere in
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // pos_x[31:0], pos_y[63:32], pos_z[95:64], radius[126:96]
  // result out
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata   // visible[0]
);

`include "assert_macros.svh"

  // Configuration registers
  logic        cull_en_r;
  logic [63:0] row0_r, row1_r, row2_r, row3_lo_r, row3_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cull_en_r <= 1'b0;
      row0_r    <= '0;
      row1_r    <= '0;
      row2_r    <= '0;
      row3_lo_r <= '0;
      row3_hi_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CULL_EN: cull_en_r <= cfg_wdata[0];
        REG_ROW0:    row0_r    <= cfg_wdata;
        REG_ROW1:    row1_r    <= cfg_wdata;
        REG_ROW2:    row2_r    <= cfg_wdata;
        REG_ROW3_LO: row3_lo_r <= cfg_wdata;
        REG_ROW3_HI: row3_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage valids and ready chain
  logic v1_r, v2_r, v3_r, vo_r;
  logic rdy1, rdy2, rdy3, rdy_o;

  assign rdy_o = !vo_r || out_tready;
  assign rdy3  = !v3_r || rdy_o;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1)  v1_r <= in_tvalid;
      if (rdy2)  v2_r <= v1_r;
      if (rdy3)  v3_r <= v2_r;
      if (rdy_o) vo_r <= v3_r;
    end
  end

  // Input register and radius carried alongside
  logic signed [POS_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [RAD_W-1:0]        rad1_r, rad2_r, rad3_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      pos_x_r <= in_tdata[31:0];
      pos_y_r <= in_tdata[63:32];
      pos_z_r <= in_tdata[95:64];
      rad1_r  <= in_tdata[126:96];
    end
    if (rdy2) rad2_r <= rad1_r;
    if (rdy3) rad3_r <= rad2_r;
  end

  // Plane lanes
  lane_ctl_t               lane_ctl;
  plane_t                  planes [NUM_PLANES];
  logic signed [DIST_W-1:0] dists [NUM_PLANES];

  assign lane_ctl.ld_prod = rdy2;
  assign lane_ctl.ld_dist = rdy3;

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    localparam logic [2:0] PL = 3'(p);

    assign planes[p].x = comb_q12(PL, row0_r[15:0], row0_r[31:16],
                                  row0_r[47:32], row0_r[63:48]);
    assign planes[p].y = comb_q12(PL, row1_r[15:0], row1_r[31:16],
                                  row1_r[47:32], row1_r[63:48]);
    assign planes[p].z = comb_q12(PL, row2_r[15:0], row2_r[31:16],
                                  row2_r[47:32], row2_r[63:48]);
    assign planes[p].w = comb_q16(PL, row3_lo_r[31:0], row3_lo_r[63:32],
                                  row3_hi_r[31:0], row3_hi_r[63:32]);

    sfc_plane_lane u_lane (
      .clk        (clk),
      .plane      (planes[p]),
      .pos_x      (pos_x_r),
      .pos_y      (pos_y_r),
      .pos_z      (pos_z_r),
      .ctl        (lane_ctl),
      .plane_dist (dists[p])
    );
  end

  // Compare: distance + radius (Q.28) must not go negative
  logic signed [DIST_W-1:0] rad_q28;
  logic [NUM_PLANES-1:0]    in_frustum;
  logic                     visible_nxt, visible_r;

  assign rad_q28 = DIST_W'({1'b0, rad3_r, {FRAC_SHIFT{1'b0}}});

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      in_frustum[p] = !(dists[p] + rad_q28 < 0);
    end
    visible_nxt = !cull_en_r || (&in_frustum);
  end

  always_ff @(posedge clk) begin
    if (rdy_o) visible_r <= visible_nxt;
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {7'b0, visible_r};

  // Assertions
  `SFC_ASSERT_NEXT(a_last_stage_moves, v3_r && rdy_o, out_tvalid)
  `SFC_ASSERT_NEXT(a_stage1_holds, v1_r && !rdy2, v1_r && $stable(pos_x_r) && $stable(rad1_r))
  `SFC_ASSERT_IMPL(a_full_blocks_input, v1_r && v2_r && v3_r && vo_r && !out_tready, !in_tready)
  `SFC_ASSERT_NEXT(a_result_holds_stalled, vo_r && !out_tready, $stable(visible_r))

endmodule

// ===== rtl/core/sfc_plane_lane.sv =====
// ---------------------------------------------------------------------------
// sfc_plane_lane
// One clip plane: registered products, then registered exact distance.
// ---------------------------------------------------------------------------
module sfc_plane_lane
  import sfc_pkg::*;
(
  input  logic                     clk,
  input  plane_t                   plane,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic signed [POS_W-1:0]  pos_z,
  input  lane_ctl_t                ctl,
  output logic signed [DIST_W-1:0] plane_dist
);

  logic signed [PROD_W-1:0] px_r, py_r, pz_r;
  logic signed [PROD_W-1:0] px_nxt, py_nxt, pz_nxt;
  logic signed [DIST_W-1:0] pw_r, pw_nxt;
  logic signed [DIST_W-1:0] dist_r, dist_nxt;

  // Products, Q.28
  always_comb begin
    px_nxt = PROD_W'(plane.x) * PROD_W'(pos_x);
    py_nxt = PROD_W'(plane.y) * PROD_W'(pos_y);
    pz_nxt = PROD_W'(plane.z) * PROD_W'(pos_z);
    pw_nxt = DIST_W'(plane.w) <<< FRAC_SHIFT;
  end

  // Distance sum
  assign dist_nxt = DIST_W'(px_r) + DIST_W'(py_r) + DIST_W'(pz_r) + pw_r;

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      pz_r <= pz_nxt;
      pw_r <= pw_nxt;
    end
    if (ctl.ld_dist) begin
      dist_r <= dist_nxt;
    end
  end

  assign plane_dist = dist_r;

endmodule

// ===== verif/tb_sphere_frustum_cull.sv =====
// ---------------------------------------------------------------------------
// tb_sphere_frustum_cull
// Self-checking bench for the bounding-sphere frustum cull.
// Spheres are streamed in from a queue with random gaps, visible flags are
// taken with random back-pressure, and every flag is checked in order against
// a local plane-distance calculation. A directed set covers the field
// extremes, the exact plane boundaries, culling off, the zero matrix and the
// spare register indexes; random phases then cycle through matrix settings.
// ---------------------------------------------------------------------------
module tb_sphere_frustum_cull;
  timeunit 1ns;
  timeprecision 1ps;
  import sfc_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 5;
  localparam int IDLE_PCT       = 37;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_ITEMS    = 125;
  localparam int POS_SPAN       = 32'h0008_0000;   // +/- 8.0 in Q16.16

  // Indexes past the register list; writes there must be dropped
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  localparam logic signed [31:0] MAXP = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINP = 32'sh8000_0000;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] HALF = 32'sh0000_8000;
  localparam logic [30:0]        MAX_RAD = 31'h7FFF_FFFF;
  localparam logic [15:0]        ONE_Q12 = 16'h1000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        radius;
  } sphere_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;

  // Register copy used by the plane calculation
  bit           cull_on = 1'b0;
  logic [63:0]  mat_row [3] = '{default: '0};
  logic [63:0]  row3_lo = '0;
  logic [63:0]  row3_hi = '0;

  sphere_t      sphere_q [$];
  bit           visible_q [$];
  bit           idle_en = 1'b1;
  bit           in_taken = 1'b0;
  int           n_pushed = 0;
  int           n_accepted = 0;
  int           n_errors = 0;
  int           n_visible = 0;
  int           n_culled = 0;
  int           n_reg_writes = 0;
  int           cycle_count = 0;

  sphere_frustum_cull u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  // Plane distances, exact in 64 bits: Q5.12 x Q16.16 plus Q17.16 << 12
  function automatic bit sphere_visible(sphere_t s);
    longint     m [4][4];
    longint     pl [4];
    longint     d_sum;
    longint     neg_rad;
    logic [2:0] p;
    bit         vis;
    vis = 1'b1;
    neg_rad = -(longint'(s.radius) <<< FRAC_SHIFT);
    if (cull_on) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 4; c++)
          m[r][c] = $signed(mat_row[r][16*c +: 16]);
      m[3][0] = $signed(row3_lo[31:0]);
      m[3][1] = $signed(row3_lo[63:32]);
      m[3][2] = $signed(row3_hi[31:0]);
      m[3][3] = $signed(row3_hi[63:32]);
      for (int i = 0; i < NUM_PLANES; i++) begin
        p = 3'(i);
        for (int r = 0; r < 4; r++) begin
          case (p)
            PL_LEFT:   pl[r] = m[r][3] + m[r][0];
            PL_RIGHT:  pl[r] = m[r][3] - m[r][0];
            PL_TOP:    pl[r] = m[r][3] - m[r][1];
            PL_BOTTOM: pl[r] = m[r][3] + m[r][1];
            PL_NEAR:   pl[r] = m[r][2];
            default:   pl[r] = m[r][3] - m[r][2];
          endcase
        end
        d_sum = pl[0] * s.pos_x + pl[1] * s.pos_y + pl[2] * s.pos_z
              + (pl[3] <<< FRAC_SHIFT);
        if (d_sum < neg_rad) vis = 1'b0;
      end
    end
    return vis;
  endfunction

  function automatic logic [15:0] q12_noise();
    return 16'(int'($urandom_range(0, 512)) - 256);
  endfunction

  function automatic logic [31:0] q16_noise();
    return 32'(int'($urandom_range(0, 32'h2000)) - 32'h1000);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic add_sphere(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [31:0] z, input logic [30:0] r);
    sphere_t s;
    s.pos_x = x;
    s.pos_y = y;
    s.pos_z = z;
    s.radius = r;
    sphere_q = {sphere_q, s};
    n_pushed++;
  endtask

  task automatic add_random_sphere();
    logic signed [31:0] p [3];
    logic [30:0]        rad;
    int unsigned        pick;
    // mostly near the frustum, some with every bit free
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(99) < 20) p[i] = $urandom;
      else p[i] = 32'(int'($urandom_range(0, 2 * POS_SPAN)) - POS_SPAN);
    end
    pick = $urandom_range(99);
    if (pick < 70) rad = 31'($urandom_range(0, 32'h0002_0000));
    else if (pick < 90) rad = 31'($urandom_range(0, 32'h0100_0000));
    else rad = 31'($urandom);
    add_sphere(p[0], p[1], p[2], rad);
  endtask

  // Register write on the configuration port; only called with the pipeline empty
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_reg_writes++;
    case (idx)
      REG_CULL_EN: cull_on = val[0];
      REG_ROW0:    mat_row[0] = val;
      REG_ROW1:    mat_row[1] = val;
      REG_ROW2:    mat_row[2] = val;
      REG_ROW3_LO: row3_lo = val;
      REG_ROW3_HI: row3_hi = val;
      default: ;
    endcase
  endtask

  task automatic write_matrix(input logic [63:0] r0, input logic [63:0] r1,
                              input logic [63:0] r2, input logic [63:0] lo,
                              input logic [63:0] hi);
    write_reg(REG_ROW0, r0);
    write_reg(REG_ROW1, r1);
    write_reg(REG_ROW2, r2);
    write_reg(REG_ROW3_LO, lo);
    write_reg(REG_ROW3_HI, hi);
  endtask

  // Wait until every queued sphere is taken and every flag has come back
  task automatic drain();
    @(negedge clk);
    while (n_accepted != n_pushed || visible_q.size() != 0) @(negedge clk);
  endtask

  // Sphere driver
  always @(negedge clk) begin
    sphere_t s;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (sphere_q.size() != 0 && !(idle_en && $urandom_range(99) < IDLE_PCT)) begin
        s = sphere_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {1'b0, s.radius, s.pos_z, s.pos_y, s.pos_x};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result back-pressure
  always @(negedge clk) begin
    out_tready <= !idle_en || ($urandom_range(99) >= IDLE_PCT);
  end

  // Monitor: results are checked before this edge's sphere is predicted
  always @(posedge clk) begin
    sphere_t got;
    bit      want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        if (visible_q.size() == 0) begin
          $error("visible: expected nothing, got %0d", out_tdata[0]);
          n_errors++;
        end else begin
          want = visible_q.pop_front();
          if (out_tdata[0] !== want) begin
            $error("visible: expected %0d, got %0d", want, out_tdata[0]);
            n_errors++;
          end
          if (want) n_visible++;
          else n_culled++;
        end
      end
      if (in_tvalid && in_tready) begin
        got.pos_x = in_tdata[31:0];
        got.pos_y = in_tdata[63:32];
        got.pos_z = in_tdata[95:64];
        got.radius = in_tdata[126:96];
        visible_q = {visible_q, sphere_visible(got)};
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int left;
    int chunk;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // culling off out of reset: everything visible
    @(posedge clk);
    add_sphere(MAXP, MAXP, MAXP, MAX_RAD);
    add_sphere(MINP, MINP, MINP, '0);
    add_sphere(MINP, MAXP, 0, MAX_RAD);
    drain();

    // culling on, zero matrix: every distance is zero
    write_reg(REG_CULL_EN, '1);
    @(posedge clk);
    add_sphere(MINP, MINP, MAXP, '0);
    add_sphere(MAXP, 0, MINP, MAX_RAD);
    drain();

    // unit matrix: planes at x,y = +/-1, z = 0 and z = 1
    write_matrix(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                 64'h0000_1000_0000_0000, 64'h0, 64'h0001_0000_0000_0000);
    @(posedge clk);
    add_sphere(0, 0, HALF, '0);
    add_sphere(-(ONE + HALF), 0, HALF, HALF);      // touching left
    add_sphere(-(ONE + HALF) - 1, 0, HALF, HALF);  // just outside left
    add_sphere(ONE + HALF + 1, 0, HALF, HALF);
    add_sphere(0, ONE + HALF + 1, HALF, HALF);
    add_sphere(0, -(ONE + HALF) - 1, HALF, HALF);
    add_sphere(0, 0, -HALF, HALF);                 // touching near
    add_sphere(0, 0, -HALF - 1, HALF);
    add_sphere(0, 0, ONE + HALF + 1, HALF);
    add_sphere(MINP, 0, HALF, MAX_RAD);            // huge radius still reaches
    drain();

    // spare indexes change nothing; an even enable word turns culling off
    write_reg(REG_SPARE_6, '1);
    write_reg(REG_SPARE_7, '1);
    @(posedge clk);
    add_sphere(-(ONE + HALF) - 1, 0, HALF, HALF);
    drain();
    write_reg(REG_CULL_EN, 64'hFFFF_FFFF_FFFF_FFFE);
    @(posedge clk);
    add_sphere(-(ONE + HALF) - 1, 0, HALF, HALF);
    drain();

    // most negative and most positive entries everywhere
    write_reg(REG_CULL_EN, 64'd1);
    write_matrix(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                 64'h8000_8000_8000_8000, 64'h8000_0000_8000_0000,
                 64'h8000_0000_8000_0000);
    @(posedge clk);
    add_sphere(MAXP, MAXP, MAXP, '0);
    add_sphere(MINP, MINP, MINP, MAX_RAD);
    add_sphere(MAXP, MINP, 0, '0);
    drain();
    write_matrix(64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF,
                 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_FFFF_7FFF_FFFF,
                 64'h7FFF_FFFF_7FFF_FFFF);
    @(posedge clk);
    add_sphere(MAXP, MAXP, MAXP, MAX_RAD);
    add_sphere(MINP, MINP, MINP, '0);
    add_sphere(MINP, MAXP, MINP, '0);
    drain();

    // random phases: perspective-like and fully random matrices
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph % 2 == 0) begin
        write_matrix({q12_noise(), q12_noise(), q12_noise(),
                      16'($urandom_range(16'h0800, 16'h2000))},
                     {q12_noise(), q12_noise(),
                      16'($urandom_range(16'h0800, 16'h2000)), q12_noise()},
                     {ONE_Q12, 16'($urandom_range(16'h0400, 16'h1400)),
                      q12_noise(), q12_noise()},
                     {q16_noise(), q16_noise()},
                     {32'($urandom_range(32'h0002_0000, 32'h0006_0000)),
                      32'(-int'($urandom_range(0, 32'h0002_0000)))});
      end else begin
        write_matrix(rand64(), rand64(), rand64(), rand64(), rand64());
      end
      write_reg(REG_CULL_EN, (rand64() & ~64'd1) | 64'(ph != 5));
      @(posedge clk);
      idle_en = (ph != 3);
      left = PHASE_ITEMS;
      while (left > 0) begin
        chunk = $urandom_range(1, 40);
        if (chunk > left) chunk = left;
        repeat (chunk) add_random_sphere();
        left -= chunk;
        // sometimes hold off until the pipeline has fully emptied
        if ($urandom_range(3) == 0) drain();
        @(posedge clk);
      end
      drain();
    end

    idle_en = 1'b1;
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (visible_q.size() != 0) begin
      $error("visible: %0d results never arrived", visible_q.size());
      n_errors++;
    end
    $display("summary: %0d spheres, %0d visible and %0d culled, %0d register writes",
             n_accepted, n_visible, n_culled, n_reg_writes);
    $display("summary: plane boundaries, extreme matrices and culling on and off exercised");
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
